@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

  // operand width inside the datapath (8..64)
  localparam int WIDTH = 64;
  // width of the external field and register ports
  localparam int FIELD_W = 64;
  // bit counter of the shift-add multiplier
  localparam int CNT_W = $clog2(WIDTH);
  // configuration register index width
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  typedef logic [WIDTH-1:0] word_t;

  // request to the modular multiplier: result = x * y mod n
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t n;
  } mexp_req_t;

  // response from the modular multiplier
  typedef struct packed {
    logic  done;
    logic  busy;
    word_t result;
  } mexp_rsp_t;

endpackage

@@ rtl/mexp_mulmod.sv @@
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mexp_req_t req,
  output mexp_rsp_t rsp
);

  word_t              acc_r, acc_nxt;
  word_t              x_r;
  word_t              y_r;
  word_t              n_r;
  logic [WIDTH:0]     n2_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [WIDTH+1:0]   sum;
  logic [WIDTH+1:0]   sub1;
  logic [WIDTH+1:0]   sub2;

  // one multiplier bit per cycle: acc = 2*acc + bit*x, then reduce (sum < 3n)
  always_comb begin
    sum  = {1'b0, acc_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, x_r} : '0);
    sub1 = sum - {2'b00, n_r};
    sub2 = sum - {1'b0, n2_r};
    if (!sub2[WIDTH+1]) begin
      acc_nxt = sub2[WIDTH-1:0];
    end else if (!sub1[WIDTH+1]) begin
      acc_nxt = sub1[WIDTH-1:0];
    end else begin
      acc_nxt = sum[WIDTH-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      x_r   <= req.x;
      y_r   <= req.y;
      n_r   <= req.n;
      n2_r  <= {req.n, 1'b0};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
    end
  end

  assign rsp.done   = done_r;
  assign rsp.busy   = busy_r;
  assign rsp.result = acc_r;

  // a new product is never requested while one is in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("multiplier restarted while busy");

  // a finished product is fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < n_r))
    else $error("multiplier result not reduced");

endmodule

@@ rtl/modular_exponentiation.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------
// in       | in_valid / in_ready  | in_base   [63:0]
// out      | out_valid / out_ready| out_power [63:0]
// cfg      | cfg_we (write only)  | cfg_index [0], cfg_wdata [63:0]
//
// One shared shift-add modular multiplier does all work, one operand bit per
// cycle. An item needs one product to reduce the base, then one square per
// exponent bit below the top set bit and one multiply per set bit; zero
// exponent or zero modulus skips the multiplier.
// in_ready is high only when the sequencer is idle; a finished result waits
// in the output register, so the next item can enter while it stalls.
// Reset is synchronous: modulus and exponent return to 1, no item in flight.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   in_base,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_W-1:0]   out_power,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  word_t      mod_r;
  word_t      exp_r;
  word_t      e_r, e_nxt;
  word_t      sq_r, sq_nxt;
  word_t      acc_r, acc_nxt;
  word_t      one_n;
  word_t      e_shift;
  logic       out_valid_r;
  word_t      out_power_r;
  logic       out_load;
  mexp_req_t  req;
  mexp_rsp_t  rsp;

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= WIDTH'(1);
      exp_r <= WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  mod_r <= cfg_wdata[WIDTH-1:0];
        REG_EXPONENT: exp_r <= cfg_wdata[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // 1 mod n
  assign one_n   = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign e_shift = e_r >> 1;

  // square-and-multiply sequencer
  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    req.start = 1'b0;
    req.x     = sq_r;
    req.y     = sq_r;
    req.n     = mod_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (exp_r == '0) begin
            acc_nxt   = WIDTH'(1);
            state_nxt = S_FIN;
          end else if (mod_r == '0) begin
            acc_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            // reduce the base: (1 mod n) * base mod n
            acc_nxt   = one_n;
            e_nxt     = exp_r;
            req.start = 1'b1;
            req.x     = one_n;
            req.y     = in_base[WIDTH-1:0];
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (rsp.done) begin
          sq_nxt    = rsp.result;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (e_r[0]) begin
          req.start = 1'b1;
          req.x     = acc_r;
          state_nxt = S_MUL;
        end else begin
          e_nxt     = e_shift;
          req.start = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.result;
          e_nxt   = e_shift;
          if (e_shift == '0) begin
            state_nxt = S_FIN;
          end else begin
            req.start = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (rsp.done) begin
          sq_nxt    = rsp.result;
          state_nxt = S_BIT;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
  end

  // output register
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_power_r <= acc_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_power = FIELD_W'(out_power_r);

  // the multiplier only reports back while a product is awaited
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_RED || state_r == S_MUL || state_r == S_SQR))
    else $error("unexpected multiplier completion");

  // a bit step always has exponent bits left
  a_exp_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BIT |-> e_r != '0)
    else $error("bit step with exhausted exponent");

  // waiting states keep the multiplier running
  a_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_SQR || state_r == S_RED) |->
      (rsp.busy || rsp.done))
    else $error("sequencer waiting on idle multiplier");

endmodule
